// ===== rtl/rrshp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo health poller package
// Shared widths, codes and the structs that pass between the table, the
// health counter and the top level.
// ----------------------------------------------------------------------------
package rrshp_pkg;

   localparam int MAX_SERVOS  = 32;
   localparam int INDEX_WIDTH = $clog2(MAX_SERVOS);
   localparam int COUNT_WIDTH = $clog2(MAX_SERVOS + 1);
   localparam int MISS_WIDTH  = 4;
   localparam int POS_WIDTH   = 16;
   localparam int TALLY_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 6;

   // Poll outcome codes; any code other than ok or busy counts as a failure
   localparam logic [1:0] OUTCOME_BUSY = 2'd0;
   localparam logic [1:0] OUTCOME_OK   = 2'd1;
   localparam logic [1:0] OUTCOME_FAIL = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SERVOS_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_LIMIT    = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] SERVOS_IN_USE_RESET = 6'd18;
   localparam logic [MISS_WIDTH-1:0]     MISS_LIMIT_RESET    = 4'd3;

   typedef enum logic [1:0] {
      COLOR_RED    = 2'd0,
      COLOR_YELLOW = 2'd1,
      COLOR_GREEN  = 2'd2,
      COLOR_NONE   = 2'd3
   } color_type;

   // Outcome of one table update
   typedef struct packed {
      logic                   updated;
      logic [INDEX_WIDTH-1:0] index;
      logic                   alive;
      logic                   old_alive;
      logic [POS_WIDTH-1:0]   position;
      logic [TALLY_WIDTH-1:0] poll_count;
      logic [TALLY_WIDTH-1:0] failure_count;
      logic [INDEX_WIDTH-1:0] next_index;
   } entry_type;

   // Health summary for one word
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] healthy;
      color_type              color;
      logic                   changed;
   } health_type;

endpackage
`default_nettype wire

// ===== rtl/rrshp_servo_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Servo status table
// Holds the per-servo entries and the round-robin index, and computes the
// updated entry for the servo polled last.
// ----------------------------------------------------------------------------
module rrshp_servo_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                fire,
   input  wire logic [1:0]                          outcome,
   input  wire logic [rrshp_pkg::POS_WIDTH-1:0]     position,
   input  wire logic [rrshp_pkg::MISS_WIDTH-1:0]    miss_limit,
   input  wire logic [rrshp_pkg::COUNT_WIDTH-1:0]   servo_count,
   output rrshp_pkg::entry_type                     entry,
   output logic [rrshp_pkg::MAX_SERVOS-1:0]         alive_flags
);

   logic                                 started_ff;
   logic [rrshp_pkg::INDEX_WIDTH-1:0]    index_ff;
   logic [rrshp_pkg::MAX_SERVOS-1:0]     alive_ff;
   logic [rrshp_pkg::MISS_WIDTH-1:0]     miss_ff  [rrshp_pkg::MAX_SERVOS];
   logic [rrshp_pkg::POS_WIDTH-1:0]      pos_ff   [rrshp_pkg::MAX_SERVOS];
   logic [rrshp_pkg::TALLY_WIDTH-1:0]    polls_ff [rrshp_pkg::MAX_SERVOS];
   logic [rrshp_pkg::TALLY_WIDTH-1:0]    fails_ff [rrshp_pkg::MAX_SERVOS];

   logic [rrshp_pkg::INDEX_WIDTH-1:0]    index_in;
   logic                                 alive_in;
   logic [rrshp_pkg::MISS_WIDTH-1:0]     miss_in;
   logic [rrshp_pkg::POS_WIDTH-1:0]      pos_in;
   logic [rrshp_pkg::TALLY_WIDTH-1:0]    polls_in;
   logic [rrshp_pkg::TALLY_WIDTH-1:0]    fails_in;
   logic [rrshp_pkg::MISS_WIDTH:0]       miss_sum;
   logic [rrshp_pkg::COUNT_WIDTH-1:0]    index_step;

   assign alive_flags = alive_ff;

   // Compute the updated entry and the next index
   always_comb begin
      alive_in = alive_ff[index_ff];
      miss_in  = miss_ff[index_ff];
      pos_in   = pos_ff[index_ff];
      polls_in = polls_ff[index_ff] + 32'd1;
      fails_in = fails_ff[index_ff];
      miss_sum = {1'b0, miss_ff[index_ff]} + 5'd1;
      if (outcome == rrshp_pkg::OUTCOME_OK) begin
         alive_in = 1'b1;
         miss_in  = '0;
         pos_in   = position;
      end else begin
         fails_in = fails_ff[index_ff] + 32'd1;
         if (miss_sum >= {1'b0, miss_limit}) begin
            miss_in  = miss_limit;
            alive_in = 1'b0;
            pos_in   = '0;
         end else begin
            miss_in = miss_sum[rrshp_pkg::MISS_WIDTH-1:0];
         end
      end

      // Advance round robin; wrap when the index reaches the servo count
      index_step = {1'b0, index_ff} + 6'd1;
      if (!started_ff || index_step >= servo_count) begin
         index_in = '0;
      end else begin
         index_in = index_step[rrshp_pkg::INDEX_WIDTH-1:0];
      end

      entry.updated    = started_ff;
      entry.old_alive  = alive_ff[index_ff];
      entry.next_index = index_in;
      if (started_ff) begin
         entry.index         = index_ff;
         entry.alive         = alive_in;
         entry.position      = pos_in;
         entry.poll_count    = polls_in;
         entry.failure_count = fails_in;
      end else begin
         entry.index         = '0;
         entry.alive         = 1'b0;
         entry.position      = '0;
         entry.poll_count    = '0;
         entry.failure_count = '0;
      end
   end

   // Write back the entry; the first word after reset only starts polling
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         index_ff   <= '0;
         alive_ff   <= '0;
         for (int i = 0; i < rrshp_pkg::MAX_SERVOS; i++) begin
            miss_ff[i]  <= '0;
            pos_ff[i]   <= '0;
            polls_ff[i] <= '0;
            fails_ff[i] <= '0;
         end
      end else if (fire) begin
         started_ff <= 1'b1;
         index_ff   <= index_in;
         if (started_ff) begin
            alive_ff[index_ff] <= alive_in;
            miss_ff[index_ff]  <= miss_in;
            pos_ff[index_ff]   <= pos_in;
            polls_ff[index_ff] <= polls_in;
            fails_ff[index_ff] <= fails_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/rrshp_health.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Health counter
// Keeps the running count of responding servos, updated per entry change,
// recounted over the table after the servo count is rewritten.
// ----------------------------------------------------------------------------
module rrshp_health (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                fire,
   input  wire logic                                recount_start,
   input  wire rrshp_pkg::entry_type                entry,
   input  wire logic [rrshp_pkg::COUNT_WIDTH-1:0]   servo_count,
   input  wire logic [rrshp_pkg::MAX_SERVOS-1:0]    alive_flags,
   output rrshp_pkg::health_type                    health,
   output logic                                     busy
);

   logic [rrshp_pkg::COUNT_WIDTH-1:0]  healthy_ff;
   logic [rrshp_pkg::COUNT_WIDTH-1:0]  healthy_in;
   rrshp_pkg::color_type               last_color_ff;
   rrshp_pkg::color_type               color_in;
   logic                               busy_ff;
   logic [rrshp_pkg::INDEX_WIDTH-1:0]  sweep_ff;
   logic                               in_range;
   logic                               sweep_flag;

   assign busy = busy_ff;

   // Adjust the count by the updated entry and pick the color
   always_comb begin
      in_range = entry.updated && ({1'b0, entry.index} < servo_count);
      healthy_in = healthy_ff
                 + {{(rrshp_pkg::COUNT_WIDTH-1){1'b0}}, in_range & entry.alive}
                 - {{(rrshp_pkg::COUNT_WIDTH-1){1'b0}}, in_range & entry.old_alive};
      priority if (healthy_in == '0) begin
         color_in = rrshp_pkg::COLOR_RED;
      end else if (healthy_in < servo_count) begin
         color_in = rrshp_pkg::COLOR_YELLOW;
      end else begin
         color_in = rrshp_pkg::COLOR_GREEN;
      end
      health.healthy = healthy_in;
      health.color   = color_in;
      health.changed = (color_in != last_color_ff);
   end

   // One flag per cycle during a recount sweep
   assign sweep_flag = alive_flags[sweep_ff] && ({1'b0, sweep_ff} < servo_count);

   // Hold the count, sweep after a servo count write, advance per word
   always_ff @(posedge clock) begin
      if (reset) begin
         healthy_ff    <= '0;
         last_color_ff <= rrshp_pkg::COLOR_NONE;
         busy_ff       <= 1'b0;
         sweep_ff      <= '0;
      end else if (recount_start) begin
         healthy_ff <= '0;
         busy_ff    <= 1'b1;
         sweep_ff   <= '0;
      end else if (busy_ff) begin
         healthy_ff <= healthy_ff + {{(rrshp_pkg::COUNT_WIDTH-1){1'b0}}, sweep_flag};
         sweep_ff   <= sweep_ff + rrshp_pkg::INDEX_WIDTH'(1);
         if (sweep_ff == rrshp_pkg::INDEX_WIDTH'(rrshp_pkg::MAX_SERVOS - 1)) begin
            busy_ff <= 1'b0;
         end
      end else if (fire) begin
         healthy_ff    <= healthy_in;
         last_color_ff <= color_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/round_robin_servo_health_poller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin servo health poller
// Each request word reports the outcome of the last position poll. A busy
// outcome is taken and dropped. Any other outcome updates the polled servo's
// entry (except for the first such word after reset), advances the poll index
// and yields one response word with the next servo ID, the updated entry and
// the red/yellow/green health status.
//
// The request word is registered; the table update and the response
// register write then happen in the same cycle, once the response register
// is free. One word per cycle is sustained while neither rsp_stall nor a
// recount holds the flow.
// While rsp_stall is high the response register holds and the request
// register fills; req_stall then rises until the response is taken.
// Reset clears the table, the index and the valid flags, and sets the
// configuration registers to their defaults. Writing servos_in_use starts a
// recount of responding servos over the whole table, with req_stall high while it runs; csr_ready is always high.
// ----------------------------------------------------------------------------
module round_robin_servo_health_poller (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // Request channel
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [1:0]                                req_poll_outcome,
   input  wire logic [7:0]                                req_position_low_byte,
   input  wire logic [7:0]                                req_position_high_byte,
   // Response channel
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [5:0]                                     rsp_next_servo_id,
   output logic                                           rsp_entry_updated,
   output logic [4:0]                                     rsp_updated_index,
   output logic                                           rsp_servo_responding,
   output logic [15:0]                                    rsp_servo_position,
   output logic [31:0]                                    rsp_servo_poll_count,
   output logic [31:0]                                    rsp_servo_failure_count,
   output logic [5:0]                                     rsp_healthy_total,
   output logic [1:0]                                     rsp_health_color,
   output logic                                           rsp_color_changed,
   // Configuration write channel
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [rrshp_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [rrshp_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   logic [rrshp_pkg::CSR_DATA_WIDTH-1:0]  servos_in_use_ff;
   logic [rrshp_pkg::MISS_WIDTH-1:0]      miss_limit_ff;
   logic [rrshp_pkg::COUNT_WIDTH-1:0]     servo_count;
   logic                                  csr_write;
   logic                                  recount_start;

   logic                                  in_valid_ff;
   logic                                  in_valid_in;
   logic [1:0]                            in_outcome_ff;
   logic [rrshp_pkg::POS_WIDTH-1:0]       in_position_ff;

   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic                                  advance;
   logic                                  fire;
   logic                                  req_take;

   rrshp_pkg::entry_type                  entry;
   rrshp_pkg::health_type                 health;
   logic [rrshp_pkg::MAX_SERVOS-1:0]      alive_flags;
   logic                                  recount_busy;

   logic [5:0]                            next_id_ff;
   logic                                  updated_ff;
   logic [4:0]                            index_ff;
   logic                                  alive_ff;
   logic [15:0]                           position_ff;
   logic [31:0]                           polls_ff;
   logic [31:0]                           fails_ff;
   logic [5:0]                            healthy_ff;
   rrshp_pkg::color_type                  color_ff;
   logic                                  changed_ff;

   // Configuration registers
   assign csr_ready     = 1'b1;
   assign csr_write     = csr_valid && csr_ready;
   assign recount_start = csr_write && (csr_index == rrshp_pkg::CSR_SERVOS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         servos_in_use_ff <= rrshp_pkg::SERVOS_IN_USE_RESET;
         miss_limit_ff    <= rrshp_pkg::MISS_LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == rrshp_pkg::CSR_SERVOS_IN_USE) begin
            servos_in_use_ff <= csr_data;
         end
         if (csr_index == rrshp_pkg::CSR_MISS_LIMIT) begin
            miss_limit_ff <= csr_data[rrshp_pkg::MISS_WIDTH-1:0];
         end
      end
   end

   // Clamp the servo count into one through the table depth
   always_comb begin
      priority if (servos_in_use_ff == '0) begin
         servo_count = rrshp_pkg::COUNT_WIDTH'(1);
      end else if ({1'b0, servos_in_use_ff} > 7'(rrshp_pkg::MAX_SERVOS)) begin
         servo_count = rrshp_pkg::COUNT_WIDTH'(rrshp_pkg::MAX_SERVOS);
      end else begin
         servo_count = servos_in_use_ff[rrshp_pkg::COUNT_WIDTH-1:0];
      end
   end

   // Handshake: the result register frees the update stage
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = recount_busy || (in_valid_ff && !advance);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      // Drop busy words at the door
      if (req_take && req_poll_outcome != rrshp_pkg::OUTCOME_BUSY) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_outcome_ff  <= req_poll_outcome;
         in_position_ff <= {req_position_high_byte, req_position_low_byte};
      end
   end

   rrshp_servo_table u_table (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .outcome     (in_outcome_ff),
      .position    (in_position_ff),
      .miss_limit  (miss_limit_ff),
      .servo_count (servo_count),
      .entry       (entry),
      .alive_flags (alive_flags)
   );

   rrshp_health u_health (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .recount_start (recount_start),
      .entry         (entry),
      .servo_count   (servo_count),
      .alive_flags   (alive_flags),
      .health        (health),
      .busy          (recount_busy)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (fire) begin
         next_id_ff  <= {1'b0, entry.next_index} + 6'd1;
         updated_ff  <= entry.updated;
         index_ff    <= entry.index;
         alive_ff    <= entry.alive;
         position_ff <= entry.position;
         polls_ff    <= entry.poll_count;
         fails_ff    <= entry.failure_count;
         healthy_ff  <= health.healthy;
         color_ff    <= health.color;
         changed_ff  <= health.changed;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_next_servo_id       = next_id_ff;
   assign rsp_entry_updated       = updated_ff;
   assign rsp_updated_index       = index_ff;
   assign rsp_servo_responding    = alive_ff;
   assign rsp_servo_position      = position_ff;
   assign rsp_servo_poll_count    = polls_ff;
   assign rsp_servo_failure_count = fails_ff;
   assign rsp_healthy_total       = healthy_ff;
   assign rsp_health_color        = color_ff;
   assign rsp_color_changed       = changed_ff;

endmodule
`default_nettype wire
